@@ rtl/core/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation codes, widths and shared types for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned OpW   = 3;

    typedef enum logic [OpW-1:0] {
        OP_ADD = 3'd0,
        OP_MUL = 3'd1,
        OP_GT  = 3'd2,
        OP_EQ  = 3'd3,
        OP_RED = 3'd4
    } t_op;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [WordW-1:0] dividend;
        logic [WordW-1:0] divisor;
    } t_div_req;

    // Status from the shared divider.
    typedef struct packed {
        logic             done;
        logic [WordW-1:0] quot;
        logic [WordW-1:0] rem;
    } t_div_rsp;

endpackage

@@ rtl/core/rau_if.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit channel interfaces
// Valid/ready channels for the request and result sides.
// ----------------------------------------------------------------------------
interface rau_req_if import rau_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OpW-1:0]          operation;
    logic signed [WordW-1:0] a_num;
    logic [WordW-1:0]        a_den;
    logic signed [WordW-1:0] b_num;
    logic [WordW-1:0]        b_den;

    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_res_if import rau_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [WordW-1:0] res_num;
    logic [WordW-1:0]        res_den;
    logic                    compare_true;
    logic                    zero_gcd;

    modport source (output valid, res_num, res_den, compare_true, zero_gcd, input ready);
    modport sink   (input valid, res_num, res_den, compare_true, zero_gcd, output ready);
endinterface

@@ rtl/core/rational_arithmetic_unit_core.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit core
// Fraction add, multiply, compare and reduce under a small sequencer that
// shares one 33x33 multiplier and one bit-serial divider.
// ----------------------------------------------------------------------------
// Usage: a request on i_req carries an operation and two fractions; exactly
// one result follows on o_res. The block takes one request at a time: ready
// is high only while the sequencer is idle, and it stays low until the result
// has been taken by the receiver.
// Sequence: add, multiply and compare step through S_MUL1, S_MUL2 and S_FIN
// to S_OUT, taking two products of the shared 33x33 multiplier, one per
// cycle, and a third, the denominator product, for add. Reduce runs the
// Euclidean gcd on the shared divider, one division per remainder step, then
// two more divisions for numerator and denominator; zero over zero skips
// both divisions and sets zero_gcd.
// After the result is accepted, a new request is taken in the next cycle.
// Reset: synchronous active-low; the sequencer returns to idle and any
// pending result is dropped. When the receiver stalls, the result holds
// in the output register and no new request is taken.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core import rau_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rau_req_if.sink   i_req,
    rau_res_if.source o_res
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL1  = 8'b0000_0010,
        S_MUL2  = 8'b0000_0100,
        S_FIN   = 8'b0000_1000,
        S_GCD   = 8'b0001_0000,
        S_DIVN  = 8'b0010_0000,
        S_DIVD  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [OpW-1:0]          r_op;
    logic signed [WordW-1:0] r_an, r_bn;
    logic [WordW-1:0]        r_ad, r_bd;
    logic [WordW-1:0]        r_x, r_y;
    logic signed [2*WordW+1:0] r_p1, r_p2;
    logic [WordW-1:0]        r_gcd;
    logic                    r_wait;
    logic signed [WordW-1:0] r_rn;
    logic [WordW-1:0]        r_rd;
    logic                    r_cmp, r_zg;

    // Shared multiplier with 33-bit signed operands.
    logic signed [WordW:0]     w_ma, w_mb;
    logic signed [2*WordW+1:0] w_prod;
    t_div_req w_dreq;
    t_div_rsp w_drsp;
    logic                    w_neg;
    logic [WordW-1:0]        w_mag;

    assign w_neg = r_an[WordW-1];
    assign w_mag = w_neg ? (WordW'(0) - r_an) : r_an;
    assign w_prod = w_ma * w_mb;

    always_comb begin
        w_ma = {r_an[WordW-1], r_an};
        w_mb = {1'b0, r_bd};
        if (r_state == S_MUL2) begin
            if (r_op == OP_MUL) begin
                w_ma = {1'b0, r_ad};
                w_mb = {1'b0, r_bd};
            end else begin
                w_ma = {r_bn[WordW-1], r_bn};
                w_mb = {1'b0, r_ad};
            end
        end else if (r_state == S_FIN) begin
            // Denominator product for add.
            w_ma = {1'b0, r_ad};
            w_mb = {1'b0, r_bd};
        end else if (r_op == OP_MUL) begin
            w_mb = {r_bn[WordW-1], r_bn};
        end
    end

    rau_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // Divider requests.
    always_comb begin
        w_dreq.start    = 1'b0;
        w_dreq.dividend = r_x;
        w_dreq.divisor  = r_y;
        if (r_state == S_GCD && !r_wait && r_y != '0) begin
            w_dreq.start = 1'b1;
        end else if (r_state == S_DIVN && !r_wait) begin
            w_dreq.start    = 1'b1;
            w_dreq.dividend = w_mag;
            w_dreq.divisor  = r_gcd;
        end else if (r_state == S_DIVD && !r_wait) begin
            w_dreq.start    = 1'b1;
            w_dreq.dividend = r_ad;
            w_dreq.divisor  = r_gcd;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req.valid) begin
                n_state = (t_op'(i_req.operation) == OP_RED) ? S_GCD : S_MUL1;
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_FIN;
            S_FIN:  n_state = S_OUT;
            S_GCD:  if (!r_wait && r_y == '0) begin
                n_state = (r_x == '0) ? S_OUT : S_DIVN;
            end
            S_DIVN: if (r_wait && w_drsp.done) n_state = S_DIVD;
            S_DIVD: if (r_wait && w_drsp.done) n_state = S_OUT;
            S_OUT:  if (o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_dreq.start) r_wait <= 1'b1;
            else if (w_drsp.done) r_wait <= 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                r_op  <= i_req.operation;
                r_an  <= i_req.a_num;
                r_ad  <= i_req.a_den;
                r_bn  <= i_req.b_num;
                r_bd  <= i_req.b_den;
                r_x   <= i_req.a_num[WordW-1] ? (WordW'(0) - i_req.a_num) : i_req.a_num;
                r_y   <= i_req.a_den;
                r_rn  <= '0;
                r_rd  <= '0;
                r_cmp <= 1'b0;
                r_zg  <= 1'b0;
            end
            S_MUL1: r_p1 <= w_prod;
            S_MUL2: r_p2 <= w_prod;
            S_FIN: begin
                case (r_op)
                    OP_ADD: begin
                        r_rn <= r_p1[WordW-1:0] + r_p2[WordW-1:0];
                        r_rd <= w_prod[WordW-1:0];
                    end
                    OP_MUL: begin
                        r_rn <= r_p1[WordW-1:0];
                        r_rd <= r_p2[WordW-1:0];
                    end
                    OP_GT: r_cmp <= (r_p1 > r_p2);
                    OP_EQ: r_cmp <= (r_p1 == r_p2);
                    default: ;
                endcase
            end
            S_GCD: begin
                if (r_wait && w_drsp.done) begin
                    r_x <= r_y;
                    r_y <= w_drsp.rem;
                end else if (!r_wait && r_y == '0) begin
                    r_gcd <= r_x;
                    if (r_x == '0) begin
                        r_rn <= r_an;
                        r_rd <= r_ad;
                        r_zg <= 1'b1;
                    end
                end
            end
            S_DIVN: if (r_wait && w_drsp.done) begin
                r_rn <= w_neg ? (WordW'(0) - w_drsp.quot) : w_drsp.quot;
            end
            S_DIVD: if (r_wait && w_drsp.done) r_rd <= w_drsp.quot;
            default: ;
        endcase
    end

    assign o_res.valid        = (r_state == S_OUT);
    assign o_res.res_num      = r_rn;
    assign o_res.res_den      = r_rd;
    assign o_res.compare_true = r_cmp;
    assign o_res.zero_gcd     = r_zg;

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> $stable(r_rn) && $stable(r_rd))
        else $error("result changed while stalled");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_req.ready)
        else $error("ready while result pending");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.compare_true && o_res.zero_gcd))
        else $error("compare and zero gcd both set");

endmodule

@@ rtl/core/rau_divider.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring divider, one quotient bit per cycle. Division by zero gives
// a quotient of all ones and the dividend as remainder.
// ----------------------------------------------------------------------------
module rau_divider import rau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int unsigned CntW = $clog2(WordW + 1);

    logic [WordW-1:0] r_quot, n_quot;
    logic [WordW-1:0] r_rem, n_rem;
    logic [WordW-1:0] r_dsr, n_dsr;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [WordW:0]   w_trial;
    logic [WordW:0]   w_diff;

    // One shift and subtract step per cycle.
    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_dsr   = r_dsr;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem, r_quot[WordW-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        if (i_req.start) begin
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_dsr  = i_req.divisor;
            n_cnt  = CntW'(WordW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[WordW]) begin
                n_rem  = w_diff[WordW-1:0];
                n_quot = {r_quot[WordW-2:0], 1'b1};
            end else begin
                n_rem  = w_trial[WordW-1:0];
                n_quot = {r_quot[WordW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

    // A finished division is preceded by a busy cycle.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("divider busy with zero count");
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !$past(i_req.start)) |-> !r_busy)
        else $error("divider still busy after done");

endmodule
